// ----- sv/ubxfp_pkg.sv -----
package ubxfp_pkg;

  // Default limits
  localparam int MaxPayloadDefault   = 92;
  localparam int FixTypeOffsetDefault = 20;

  // Framing and message codes
  localparam logic [7:0] SYNC_FIRST  = 8'hB5;
  localparam logic [7:0] SYNC_SECOND = 8'h62;
  localparam logic [7:0] NAV_CLASS   = 8'h01;
  localparam logic [7:0] PVT_IDENT   = 8'h07;
  localparam logic [7:0] FIX_3D_CODE = 8'h03;

  // Parser phases
  typedef enum logic [3:0] {
    PH_SYNC1,
    PH_SYNC2,
    PH_CLASS,
    PH_IDENT,
    PH_LEN_LO,
    PH_LEN_HI,
    PH_PAYLOAD,
    PH_CHECK_A,
    PH_CHECK_B
  } phase_t;

  // One result word
  typedef struct packed {
    logic        frame_good;
    logic        frame_bad;
    logic [7:0]  msg_class;
    logic [7:0]  msg_ident;
    logic [15:0] frame_length;
    logic        fix_3d;
  } result_t;

endpackage

// ----- sv/ubx_frame_parser_unit.sv -----
// Channel  | valid     | stall     | payload
// ---------+-----------+-----------+---------------------------------------------
// rx       | rx_valid  | rx_stall  | rx_byte
// res      | res_valid | res_stall | frame_good, frame_bad, msg_class, msg_ident,
//          |           |           | frame_length, fix_3d
//
// One byte per cycle while rx_stall is low: the parser state is updated in the
// accepting cycle and the result word goes to the output or the skid register.
// Synchronous active-high reset clears the parser state, sums, header fields,
// the held fix-type byte and marks both output words empty; no clearing pass
// is needed.
// A two-word output buffer (output register plus skid register) lets rx keep
// taking a byte while a result waits; rx_stall rises only when both are full.
module ubx_frame_parser_unit #(
  parameter int MAX_PAYLOAD     = ubxfp_pkg::MaxPayloadDefault,
  parameter int FIX_TYPE_OFFSET = ubxfp_pkg::FixTypeOffsetDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        rx_valid,
  output logic        rx_stall,
  input  logic [7:0]  rx_byte,
  output logic        res_valid,
  input  logic        res_stall,
  output logic        frame_good,
  output logic        frame_bad,
  output logic [7:0]  msg_class,
  output logic [7:0]  msg_ident,
  output logic [15:0] frame_length,
  output logic        fix_3d
);
  import ubxfp_pkg::*;

  localparam int CW = $clog2(MAX_PAYLOAD + 1);
  localparam bit FT_VALID = (FIX_TYPE_OFFSET < MAX_PAYLOAD);
  localparam logic [CW-1:0] FT_IDX = CW'(FIX_TYPE_OFFSET);
  localparam logic [15:0] MAX_LEN = 16'(MAX_PAYLOAD);

  // Parser state
  phase_t        phase, phase_next;
  logic [7:0]    sum_a, sum_a_next;
  logic [7:0]    sum_b, sum_b_next;
  logic [7:0]    class_reg, class_reg_next;
  logic [7:0]    ident_reg, ident_reg_next;
  logic [15:0]   length_reg, length_reg_next;
  logic [CW-1:0] byte_count, byte_count_next;
  // Only the fix-type entry of the payload store is ever read, so only it is kept
  logic [7:0]    fix_byte, fix_byte_next;
  logic          fix_flag, fix_flag_next;

  // Output buffer
  result_t out_word, skid_word, res_next;
  logic    out_full, skid_full;

  logic          accept;
  logic          take;
  logic [15:0]   len_new;
  logic [15:0]   count_inc;
  logic [7:0]    add_a;
  logic          do_add;
  logic          good, bad;

  assign accept    = rx_valid && !rx_stall;
  assign take      = out_full && !res_stall;
  assign rx_stall  = skid_full;
  assign len_new   = {rx_byte, length_reg[7:0]};
  assign count_inc = 16'(byte_count) + 16'd1;
  assign add_a     = sum_a + rx_byte;

  // Next phase
  always_comb begin
    phase_next = phase;
    unique case (phase)
      PH_SYNC1:   if (rx_byte == SYNC_FIRST) phase_next = PH_SYNC2;
      PH_SYNC2:   phase_next = (rx_byte == SYNC_SECOND) ? PH_CLASS : PH_SYNC1;
      PH_CLASS:   phase_next = PH_IDENT;
      PH_IDENT:   phase_next = PH_LEN_LO;
      PH_LEN_LO:  phase_next = PH_LEN_HI;
      PH_LEN_HI: begin
        if (len_new > MAX_LEN)      phase_next = PH_SYNC1;
        else if (len_new == 16'd0)  phase_next = PH_CHECK_A;
        else                        phase_next = PH_PAYLOAD;
      end
      PH_PAYLOAD: if (count_inc >= length_reg) phase_next = PH_CHECK_A;
      PH_CHECK_A: phase_next = (rx_byte == sum_a) ? PH_CHECK_B : PH_SYNC1;
      PH_CHECK_B: phase_next = PH_SYNC1;
      default:    phase_next = PH_SYNC1;
    endcase
  end

  // Datapath and flags
  always_comb begin
    sum_a_next      = sum_a;
    sum_b_next      = sum_b;
    class_reg_next  = class_reg;
    ident_reg_next  = ident_reg;
    length_reg_next = length_reg;
    byte_count_next = byte_count;
    fix_byte_next   = fix_byte;
    fix_flag_next   = fix_flag;
    do_add          = 1'b0;
    good            = 1'b0;
    bad             = 1'b0;
    unique case (phase)
      PH_SYNC2: begin
        if (rx_byte == SYNC_SECOND) begin
          sum_a_next = 8'd0;
          sum_b_next = 8'd0;
        end
      end
      PH_CLASS: begin
        class_reg_next = rx_byte;
        do_add         = 1'b1;
      end
      PH_IDENT: begin
        ident_reg_next = rx_byte;
        do_add         = 1'b1;
      end
      PH_LEN_LO: begin
        length_reg_next = {8'd0, rx_byte};
        do_add          = 1'b1;
      end
      PH_LEN_HI: begin
        length_reg_next = len_new;
        byte_count_next = '0;
        do_add          = 1'b1;
        bad             = (len_new > MAX_LEN);
      end
      PH_PAYLOAD: begin
        if (FT_VALID && byte_count == FT_IDX) fix_byte_next = rx_byte;
        byte_count_next = byte_count + CW'(1);
        do_add          = 1'b1;
      end
      PH_CHECK_A: bad = (rx_byte != sum_a);
      PH_CHECK_B: begin
        if (rx_byte == sum_b) begin
          good = 1'b1;
          if (class_reg == NAV_CLASS && ident_reg == PVT_IDENT) begin
            fix_flag_next = FT_VALID && (fix_byte == FIX_3D_CODE);
          end
        end else begin
          bad = 1'b1;
        end
      end
      default: ;
    endcase
    // Fletcher pair over class through payload
    if (do_add) begin
      sum_a_next = add_a;
      sum_b_next = sum_b + add_a;
    end
  end

  assign res_next = '{frame_good: good, frame_bad: bad, msg_class: class_reg_next,
                      msg_ident: ident_reg_next, frame_length: length_reg_next,
                      fix_3d: fix_flag_next};

  // Parser registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_SYNC1;
      sum_a      <= 8'd0;
      sum_b      <= 8'd0;
      class_reg  <= 8'd0;
      ident_reg  <= 8'd0;
      length_reg <= 16'd0;
      byte_count <= '0;
      fix_byte   <= 8'd0;
      fix_flag   <= 1'b0;
    end else if (accept) begin
      phase      <= phase_next;
      sum_a      <= sum_a_next;
      sum_b      <= sum_b_next;
      class_reg  <= class_reg_next;
      ident_reg  <= ident_reg_next;
      length_reg <= length_reg_next;
      byte_count <= byte_count_next;
      fix_byte   <= fix_byte_next;
      fix_flag   <= fix_flag_next;
    end
  end

  // Output register with skid word
  always_ff @(posedge clk) begin
    if (rst) begin
      out_full  <= 1'b0;
      skid_full <= 1'b0;
    end else if (accept) begin
      if (!out_full || take) begin
        out_word <= res_next;
        out_full <= 1'b1;
      end else begin
        skid_word <= res_next;
        skid_full <= 1'b1;
      end
    end else if (take) begin
      if (skid_full) begin
        out_word  <= skid_word;
        skid_full <= 1'b0;
      end else begin
        out_full <= 1'b0;
      end
    end
  end

  assign res_valid    = out_full;
  assign frame_good   = out_word.frame_good;
  assign frame_bad    = out_word.frame_bad;
  assign msg_class    = out_word.msg_class;
  assign msg_ident    = out_word.msg_ident;
  assign frame_length = out_word.frame_length;
  assign fix_3d       = out_word.fix_3d;

endmodule
